>>> src/assert_macros.svh
// Assertion macros shared by the solver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset disable on clk_i and rst_ni.
`define QRS_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("qrs assertion failed");

// Same-cycle implication.
`define QRS_ASSERT_IMP(lbl, ante, cons) `QRS_ASSERT_CLK(lbl, (ante) |-> (cons))

`endif

>>> src/qrs_pkg.sv
// Package with shared types, constants and helpers of the quadratic root solver.
`default_nettype none

package qrs_pkg;

  localparam int OPERAND_W = 16;
  localparam int ROOT_W    = 32;
  localparam int STATUS_W  = 2;

  // Opcodes of the input word.
  localparam logic OP_COEF = 1'b0;
  localparam logic OP_FACT = 1'b1;

  // Status codes of the result word.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_LEAD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT      = 2'd2;

  localparam logic [ROOT_W-1:0] ROOT_MAX = {1'b0, {(ROOT_W-1){1'b1}}};
  localparam logic [ROOT_W-1:0] ROOT_MIN = {1'b1, {(ROOT_W-1){1'b0}}};

  // Flags that travel with a word through the divider chain.
  typedef struct packed {
    logic zero;
    logic dneg;
    logic neg0;
    logic neg1;
    logic ovf0;
    logic ovf1;
  } div_flags_t;

  // Clamp a sign and magnitude quotient to a signed root; top bit is the saturation flag.
  function automatic logic [ROOT_W:0] sat_root(input logic ovf, input logic [ROOT_W-1:0] q,
                                               input logic neg);
    logic over;
    over = ovf || (neg ? (q > ROOT_MIN) : (q > ROOT_MAX));
    if (over) begin
      return {1'b1, (neg ? ROOT_MIN : ROOT_MAX)};
    end
    return {1'b0, (neg ? (~q + 1'b1) : q)};
  endfunction

endpackage

`default_nettype wire

>>> src/qrs_sqrt_cell.sv
// One digit cell of the pipelined square root chain.
`default_nettype none

module qrs_sqrt_cell
  import qrs_pkg::*;
#(
  parameter int RB = 49,
  parameter int TW = 68
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [RB+1:0]   rem_i,
  input  wire logic [RB-1:0]   root_i,
  input  wire logic [2*RB-1:0] rad_i,
  input  wire logic [TW-1:0]   tag_i,
  output logic                 valid_o,
  output logic [RB+1:0]        rem_o,
  output logic [RB-1:0]        root_o,
  output logic [2*RB-1:0]      rad_o,
  output logic [TW-1:0]        tag_o
);

  logic [RB+3:0]   cur;
  logic [RB+3:0]   trial;
  logic [RB+3:0]   diff;
  logic [RB+1:0]   rem_d;
  logic [RB-1:0]   root_d;

  // Bring in the next two radicand bits and try the next root bit.
  always_comb begin
    cur   = {rem_i, rad_i[2*RB-1 -: 2]};
    trial = {2'b00, root_i, 2'b01};
    diff  = cur - trial;
    if (cur >= trial) begin
      rem_d  = diff[RB+1:0];
      root_d = {root_i[RB-2:0], 1'b1};
    end else begin
      rem_d  = cur[RB+1:0];
      root_d = {root_i[RB-2:0], 1'b0};
    end
  end

  // Control bit with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rem_o  <= rem_d;
    root_o <= root_d;
    rad_o  <= {rad_i[2*RB-3:0], 2'b00};
    tag_o  <= tag_i;
  end

endmodule

`default_nettype wire

>>> src/qrs_div_cell.sv
// One quotient bit cell of the two-lane pipelined divider chain.
`default_nettype none

module qrs_div_cell
  import qrs_pkg::*;
#(
  parameter int DNW = 34,
  parameter int QB  = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire logic [DNW-1:0]      den_i,
  input  wire logic [1:0][DNW-1:0] rem_i,
  input  wire logic [1:0][QB-1:0]  lo_i,
  input  wire logic [1:0][QB-1:0]  quo_i,
  input  wire div_flags_t          flags_i,
  output logic                     valid_o,
  output logic [DNW-1:0]           den_o,
  output logic [1:0][DNW-1:0]      rem_o,
  output logic [1:0][QB-1:0]       lo_o,
  output logic [1:0][QB-1:0]       quo_o,
  output div_flags_t               flags_o
);

  logic [1:0][DNW:0]   t;
  logic [1:0][DNW:0]   diff;
  logic [1:0][DNW-1:0] rem_d;
  logic [1:0][QB-1:0]  quo_d;

  // Restoring step on both lanes against the shared divisor.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      t[k]    = {rem_i[k], lo_i[k][QB-1]};
      diff[k] = t[k] - {1'b0, den_i};
      if (t[k] >= {1'b0, den_i}) begin
        rem_d[k] = diff[k][DNW-1:0];
        quo_d[k] = {quo_i[k][QB-2:0], 1'b1};
      end else begin
        rem_d[k] = t[k][DNW-1:0];
        quo_d[k] = {quo_i[k][QB-2:0], 1'b0};
      end
    end
  end

  // Control bit with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    den_o   <= den_i;
    rem_o   <= rem_d;
    quo_o   <= quo_d;
    lo_o[0] <= {lo_i[0][QB-2:0], 1'b0};
    lo_o[1] <= {lo_i[1][QB-2:0], 1'b0};
    flags_o <= flags_i;
  end

endmodule

`default_nettype wire

>>> src/quadratic_root_solver_core.sv
// From start to done_o a word passes stages 1 to 4, the square root chain, stages 5 and 6,
// the divider chain and the stage 7 result register; RB is the root bit count (49 at default).
// Throughput: one word per clock cycle; busy stays low, every cell advances each cycle.
// Reset: rst_ni clears all valid bits at once; no result is shown until a new word enters.
// Results are strobed on done_o for one cycle and are not held back by the receiver.
`default_nettype none
`include "assert_macros.svh"

module quadratic_root_solver_core
  import qrs_pkg::*;
#(
  parameter int INPUT_WIDTH         = 16,
  parameter int INPUT_FRACTION_BITS = 8,
  parameter int ROOT_FRACTION_BITS  = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        opcode_i,
  input  wire logic signed [OPERAND_W-1:0] operand_0_i,
  input  wire logic signed [OPERAND_W-1:0] operand_1_i,
  input  wire logic signed [OPERAND_W-1:0] operand_2_i,
  input  wire logic signed [OPERAND_W-1:0] operand_3_i,
  output logic                             done_o,
  output logic signed [ROOT_W-1:0]         first_root_real_o,
  output logic signed [ROOT_W-1:0]         first_root_imag_o,
  output logic signed [ROOT_W-1:0]         second_root_real_o,
  output logic signed [ROOT_W-1:0]         second_root_imag_o,
  output logic [STATUS_W-1:0]              status_o
);

  localparam int W    = INPUT_WIDTH;
  localparam int F    = INPUT_FRACTION_BITS;
  localparam int R    = ROOT_FRACTION_BITS;
  localparam int X    = ((W - 1 + F) > (2 * W - 1)) ? (W - 1 + F) : (2 * W - 1);
  localparam int KW   = X + 2;
  localparam int PW   = 2 * KW;
  localparam int DSW  = PW + 3;
  localparam int DM   = PW - 1;
  localparam int RADW = DM + 2 * R;
  localparam int RB   = (RADW + 1) / 2;
  localparam int TW   = 2 * KW + 2;
  localparam int QB   = ROOT_W;
  localparam int NA   = ((KW + R) > (RB + 1)) ? (KW + R) : (RB + 1);
  localparam int NSW  = ((NA > (QB + 1)) ? NA : (QB + 1)) + 1;
  localparam int DNW  = KW + 1;
  localparam int CW   = (NSW > (DNW + QB)) ? NSW : (DNW + QB);

  // The block never stalls.
  assign busy = 1'b0;

  // Stage 1: take the low operand bits and form the factored products.
  logic [31:0]            e0, e1, e2, e3;
  logic signed [W-1:0]    o0, o1, o2, o3;
  logic                   v1_q;
  logic                   op1_q;
  logic signed [W-1:0]    o0_q, o1_q, o2_q;
  logic signed [2*W-1:0]  p02_q, p03_q, p12_q, p13_q;

  always_comb begin
    e0 = {{(32-OPERAND_W){1'b0}}, operand_0_i};
    e1 = {{(32-OPERAND_W){1'b0}}, operand_1_i};
    e2 = {{(32-OPERAND_W){1'b0}}, operand_2_i};
    e3 = {{(32-OPERAND_W){1'b0}}, operand_3_i};
    o0 = e0[W-1:0];
    o1 = e1[W-1:0];
    o2 = e2[W-1:0];
    o3 = e3[W-1:0];
  end

  always_ff @(posedge clk_i) begin
    op1_q <= opcode_i;
    o0_q  <= o0;
    o1_q  <= o1;
    o2_q  <= o2;
    p02_q <= (2*W)'(o0) * (2*W)'(o2);
    p03_q <= (2*W)'(o0) * (2*W)'(o3);
    p12_q <= (2*W)'(o1) * (2*W)'(o2);
    p13_q <= (2*W)'(o1) * (2*W)'(o3);
  end

  // Stage 2: choose the coefficients for the opcode.
  logic                 v2_q, zero2_q;
  logic signed [KW-1:0] a_d, b_d, c_d, a2_q, b2_q, c2_q;

  always_comb begin
    if (op1_q == OP_FACT) begin
      a_d = KW'(p02_q);
      b_d = KW'(p03_q) + KW'(p12_q);
      c_d = KW'(p13_q);
    end else begin
      a_d = KW'(o0_q) <<< F;
      b_d = KW'(o1_q) <<< F;
      c_d = KW'(o2_q) <<< F;
    end
  end

  always_ff @(posedge clk_i) begin
    a2_q    <= a_d;
    b2_q    <= b_d;
    c2_q    <= c_d;
    zero2_q <= (a_d == '0);
  end

  // Stage 3: squares and cross products.
  logic                 v3_q, zero3_q;
  logic signed [KW-1:0] a3_q, b3_q;
  logic signed [PW-1:0] bb_q, ac_q;

  always_ff @(posedge clk_i) begin
    a3_q    <= a2_q;
    b3_q    <= b2_q;
    zero3_q <= zero2_q;
    bb_q    <= PW'(b2_q) * PW'(b2_q);
    ac_q    <= PW'(a2_q) * PW'(c2_q);
  end

  // Stage 4: discriminant as sign and magnitude.
  logic signed [DSW-1:0] d_d, dabs_d;
  logic                  v4_q;
  logic [DM-1:0]         dmag_q;
  logic [TW-1:0]         tag4_q;

  always_comb begin
    d_d    = DSW'(bb_q) - (DSW'(ac_q) <<< 2);
    dabs_d = d_d[DSW-1] ? -d_d : d_d;
  end

  always_ff @(posedge clk_i) begin
    dmag_q <= dabs_d[DM-1:0];
    tag4_q <= {a3_q, b3_q, zero3_q, d_d[DSW-1]};
  end

  // Valid pipeline of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Square root chain, one root bit per cell.
  logic [RB:0]     sq_v;
  logic [RB+1:0]   sq_rem  [0:RB];
  logic [RB-1:0]   sq_root [0:RB];
  logic [2*RB-1:0] sq_rad  [0:RB];
  logic [TW-1:0]   sq_tag  [0:RB];

  assign sq_v[0]    = v4_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = (2*RB)'({dmag_q, {(2*R){1'b0}}});
  assign sq_tag[0]  = tag4_q;

  for (genvar i = 0; i < RB; i++) begin : g_sqrt
    qrs_sqrt_cell #(.RB(RB), .TW(TW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .rad_i   (sq_rad[i]),
      .tag_i   (sq_tag[i]),
      .valid_o (sq_v[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .rad_o   (sq_rad[i+1]),
      .tag_o   (sq_tag[i+1])
    );
  end

  // Stage 5: numerators and divisor.
  logic signed [KW-1:0]  a5, b5;
  logic                  zero5, dneg5;
  logic signed [NSW-1:0] nb, sv, num0, num1;
  logic [KW-1:0]         aabs;
  logic                  v5_q;
  logic [NSW-1:0]        mag0_q, mag1_q;
  logic [DNW-1:0]        den5_q;
  logic                  zero5_q, dneg5_q, neg0_q, neg1_q;

  always_comb begin
    a5    = sq_tag[RB][TW-1 -: KW];
    b5    = sq_tag[RB][TW-KW-1 -: KW];
    zero5 = sq_tag[RB][1];
    dneg5 = sq_tag[RB][0];
    nb    = -(NSW'(b5) <<< R);
    sv    = NSW'($signed({1'b0, sq_root[RB]}));
    num0  = dneg5 ? nb : (nb + sv);
    num1  = dneg5 ? sv : (nb - sv);
    aabs  = a5[KW-1] ? KW'(-a5) : KW'(a5);
  end

  always_ff @(posedge clk_i) begin
    mag0_q  <= num0[NSW-1] ? NSW'(-num0) : NSW'(num0);
    mag1_q  <= num1[NSW-1] ? NSW'(-num1) : NSW'(num1);
    neg0_q  <= num0[NSW-1] ^ a5[KW-1];
    neg1_q  <= num1[NSW-1] ^ a5[KW-1];
    den5_q  <= {aabs, 1'b0};
    zero5_q <= zero5;
    dneg5_q <= dneg5;
  end

  // Stage 6: overflow check and first partial remainder.
  logic [CW-1:0]       w0, w1, wden, sh0, sh1;
  logic                v6_q;
  logic [DNW-1:0]      den6_q;
  logic [1:0][DNW-1:0] rem6_q;
  logic [1:0][QB-1:0]  lo6_q;
  div_flags_t          flags6_q;

  always_comb begin
    w0   = CW'(mag0_q);
    w1   = CW'(mag1_q);
    wden = CW'({den5_q, {QB{1'b0}}});
    sh0  = w0 >> QB;
    sh1  = w1 >> QB;
  end

  always_ff @(posedge clk_i) begin
    den6_q        <= den5_q;
    rem6_q[0]     <= sh0[DNW-1:0];
    rem6_q[1]     <= sh1[DNW-1:0];
    lo6_q[0]      <= mag0_q[QB-1:0];
    lo6_q[1]      <= mag1_q[QB-1:0];
    flags6_q.zero <= zero5_q;
    flags6_q.dneg <= dneg5_q;
    flags6_q.neg0 <= neg0_q;
    flags6_q.neg1 <= neg1_q;
    flags6_q.ovf0 <= (w0 >= wden);
    flags6_q.ovf1 <= (w1 >= wden);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v5_q <= sq_v[RB];
      v6_q <= v5_q;
    end
  end

  // Divider chain, one quotient bit per cell on both lanes.
  logic [QB:0]         dv_v;
  logic [DNW-1:0]      dv_den [0:QB];
  logic [1:0][DNW-1:0] dv_rem [0:QB];
  logic [1:0][QB-1:0]  dv_lo  [0:QB];
  logic [1:0][QB-1:0]  dv_quo [0:QB];
  div_flags_t          dv_flg [0:QB];

  assign dv_v[0]   = v6_q;
  assign dv_den[0] = den6_q;
  assign dv_rem[0] = rem6_q;
  assign dv_lo[0]  = lo6_q;
  assign dv_quo[0] = '0;
  assign dv_flg[0] = flags6_q;

  for (genvar j = 0; j < QB; j++) begin : g_div
    qrs_div_cell #(.DNW(DNW), .QB(QB)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_v[j]),
      .den_i   (dv_den[j]),
      .rem_i   (dv_rem[j]),
      .lo_i    (dv_lo[j]),
      .quo_i   (dv_quo[j]),
      .flags_i (dv_flg[j]),
      .valid_o (dv_v[j+1]),
      .den_o   (dv_den[j+1]),
      .rem_o   (dv_rem[j+1]),
      .lo_o    (dv_lo[j+1]),
      .quo_o   (dv_quo[j+1]),
      .flags_o (dv_flg[j+1])
    );
  end

  // Stage 7: clamp, place the roots and register the result word.
  div_flags_t      fl;
  logic [ROOT_W:0] s0, s1, s1n;
  logic [ROOT_W-1:0] r1r_d, r1i_d, r2r_d, r2i_d;
  logic [STATUS_W-1:0] st_d;
  logic            any_sat;

  always_comb begin
    fl  = dv_flg[QB];
    s0  = sat_root(fl.ovf0, dv_quo[QB][0], fl.neg0);
    s1  = sat_root(fl.ovf1, dv_quo[QB][1], fl.neg1);
    s1n = sat_root(fl.ovf1, dv_quo[QB][1], !fl.neg1);
    if (fl.dneg) begin
      r1r_d   = s0[ROOT_W-1:0];
      r2r_d   = s0[ROOT_W-1:0];
      r1i_d   = s1[ROOT_W-1:0];
      r2i_d   = s1n[ROOT_W-1:0];
      any_sat = s0[ROOT_W] || s1[ROOT_W] || s1n[ROOT_W];
    end else begin
      r1r_d   = s0[ROOT_W-1:0];
      r2r_d   = s1[ROOT_W-1:0];
      r1i_d   = '0;
      r2i_d   = '0;
      any_sat = s0[ROOT_W] || s1[ROOT_W];
    end
    if (fl.zero) begin
      r1r_d = '0;
      r2r_d = '0;
      r1i_d = '0;
      r2i_d = '0;
      st_d  = STATUS_ZERO_LEAD;
    end else if (any_sat) begin
      st_d = STATUS_SAT;
    end else begin
      st_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    first_root_real_o  <= r1r_d;
    first_root_imag_o  <= r1i_d;
    second_root_real_o <= r2r_d;
    second_root_imag_o <= r2i_d;
    status_o           <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= dv_v[QB];
    end
  end

  // Summary terms of the result word for the checks below.
  logic roots_zero;
  logic root_clamped;

  assign roots_zero   = (first_root_real_o == '0) && (second_root_real_o == '0) &&
                        (first_root_imag_o == '0) && (second_root_imag_o == '0);
  assign root_clamped = (first_root_real_o == ROOT_MAX) || (first_root_real_o == ROOT_MIN) ||
                        (second_root_real_o == ROOT_MAX) || (second_root_real_o == ROOT_MIN) ||
                        (first_root_imag_o == ROOT_MAX) || (first_root_imag_o == ROOT_MIN) ||
                        (second_root_imag_o == ROOT_MAX) || (second_root_imag_o == ROOT_MIN);

  // A zero leading coefficient gives all-zero roots.
  `QRS_ASSERT_IMP(a_zero_lead, done_o && status_o == STATUS_ZERO_LEAD, roots_zero)
  // A saturated word carries at least one clamped root part.
  `QRS_ASSERT_IMP(a_sat_clamped, done_o && status_o == STATUS_SAT, root_clamped)
  // Imaginary parts of an unsaturated pair are negatives of each other.
  `QRS_ASSERT_IMP(a_conj_pair, done_o && status_o == STATUS_OK, first_root_imag_o == -second_root_imag_o)

endmodule

`default_nettype wire
